// File: sv/b2r_pkg.sv
// Shared constants, codes and types of the BMP to RGB565 stream decoder.
`timescale 1ns / 1ps

package b2r_pkg;

  localparam int unsigned ROW_BYTES_MAX = 964;
  localparam int unsigned ROW_W = $clog2(ROW_BYTES_MAX + 1);
  localparam int unsigned PROD_W = ROW_W + 3;

  localparam logic [31:0] HDR_LEN  = 32'd54;
  localparam logic [31:0] HDR_LAST = HDR_LEN - 32'd1;
  localparam logic [15:0] BMP_SIG  = 16'h4D42;

  localparam logic [15:0] BPP_16 = 16'd16;
  localparam logic [15:0] BPP_24 = 16'd24;
  localparam logic [15:0] BPP_32 = 16'd32;
  localparam logic [2:0]  BPB_16 = 3'd2;

  localparam logic [5:0] OFS_SIG    = 6'd0;
  localparam logic [5:0] OFS_OFFSET = 6'd10;
  localparam logic [5:0] OFS_WIDTH  = 6'd18;
  localparam logic [5:0] OFS_HEIGHT = 6'd22;
  localparam logic [5:0] OFS_BPP    = 6'd28;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    ST_PIXEL      = 3'd0,
    ST_BAD_SIG    = 3'd1,
    ST_BAD_DEPTH  = 3'd2,
    ST_TOO_WIDE   = 3'd3,
    ST_BAD_OFFSET = 3'd4,
    ST_EMPTY      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Y = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic       wr;
    logic       check;
    logic       clear;
    logic [5:0] pos;
  } hdr_ctrl_t;

  typedef struct packed {
    status_e          status;
    logic [31:0]      data_offset;
    logic [2:0]       bpb;
    logic [ROW_W-1:0] width;
    logic [ROW_W-1:0] padded;
    logic [ROW_W-1:0] data_bytes;
    logic             height_neg;
    logic [31:0]      height_m1;
  } hdr_info_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic [15:0] screen_x;
    logic [15:0] screen_y;
    status_e     status;
    logic        last;
  } result_t;

endpackage

// File: sv/b2r_if.sv
// Handshake channel interfaces of the BMP to RGB565 stream decoder.
`timescale 1ns / 1ps

interface b2r_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink (input valid, input data_byte, input first, output ready);
endinterface

interface b2r_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel;
  logic [15:0] screen_x;
  logic [15:0] screen_y;
  logic [2:0]  status;
  logic        last;

  modport source (
    output valid, output pixel, output screen_x, output screen_y,
    output status, output last, input ready
  );
  modport sink (
    input valid, input pixel, input screen_x, input screen_y,
    input status, input last, output ready
  );
endinterface

interface b2r_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// File: sv/b2r_hdr.sv
// Header field capture and header check of the BMP to RGB565 stream decoder.
`timescale 1ns / 1ps

module b2r_hdr (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b2r_pkg::hdr_ctrl_t  ctrl_i,
  input  logic [7:0]          data_byte_i,
  output b2r_pkg::hdr_info_t  info_o
);
  import b2r_pkg::*;

  logic [15:0]       sig_q, sig_d;
  logic [31:0]       offset_q, offset_d;
  logic [31:0]       width_q, width_d;
  logic [31:0]       height_q, height_d;
  logic [15:0]       bpp_q, bpp_d;
  logic [ROW_W-1:0]  padded_q;
  logic [ROW_W-1:0]  data_bytes_q;
  logic [31:0]       height_m1_q;
  logic              height_neg_q;

  logic [2:0]        bpb;
  logic              bpp_ok;
  logic              width_hi;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rounded;
  logic [PROD_W-1:0] padded_full;
  logic              row_big;
  status_e           status;

  always_comb begin
    sig_d    = ctrl_i.clear ? '0 : sig_q;
    offset_d = ctrl_i.clear ? '0 : offset_q;
    width_d  = ctrl_i.clear ? '0 : width_q;
    height_d = ctrl_i.clear ? '0 : height_q;
    bpp_d    = ctrl_i.clear ? '0 : bpp_q;
    if (ctrl_i.wr) begin
      unique case (ctrl_i.pos)
        OFS_SIG:             sig_d[7:0]      = data_byte_i;
        OFS_SIG + 6'd1:      sig_d[15:8]     = data_byte_i;
        OFS_OFFSET:          offset_d[7:0]   = data_byte_i;
        OFS_OFFSET + 6'd1:   offset_d[15:8]  = data_byte_i;
        OFS_OFFSET + 6'd2:   offset_d[23:16] = data_byte_i;
        OFS_OFFSET + 6'd3:   offset_d[31:24] = data_byte_i;
        OFS_WIDTH:           width_d[7:0]    = data_byte_i;
        OFS_WIDTH + 6'd1:    width_d[15:8]   = data_byte_i;
        OFS_WIDTH + 6'd2:    width_d[23:16]  = data_byte_i;
        OFS_WIDTH + 6'd3:    width_d[31:24]  = data_byte_i;
        OFS_HEIGHT:          height_d[7:0]   = data_byte_i;
        OFS_HEIGHT + 6'd1:   height_d[15:8]  = data_byte_i;
        OFS_HEIGHT + 6'd2:   height_d[23:16] = data_byte_i;
        OFS_HEIGHT + 6'd3:   height_d[31:24] = data_byte_i;
        OFS_BPP:             bpp_d[7:0]      = data_byte_i;
        OFS_BPP + 6'd1:      bpp_d[15:8]     = data_byte_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    bpb         = bpp_q[5:3];
    bpp_ok      = (bpp_q == BPP_16) || (bpp_q == BPP_24) || (bpp_q == BPP_32);
    width_hi    = width_q[31:ROW_W] != '0;
    prod        = PROD_W'(width_q[ROW_W-1:0]) * PROD_W'(bpb);
    rounded     = prod + PROD_W'(3);
    padded_full = {rounded[PROD_W-1:2], 2'b00};
    row_big     = width_hi || (padded_full > PROD_W'(ROW_BYTES_MAX));
    priority if (sig_q != BMP_SIG) begin
      status = ST_BAD_SIG;
    end else if (!bpp_ok) begin
      status = ST_BAD_DEPTH;
    end else if (row_big) begin
      status = ST_TOO_WIDE;
    end else if (offset_q < HDR_LEN) begin
      status = ST_BAD_OFFSET;
    end else if (width_q == '0 || height_q == '0) begin
      status = ST_EMPTY;
    end else begin
      status = ST_PIXEL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q    <= '0;
      offset_q <= '0;
      width_q  <= '0;
      height_q <= '0;
      bpp_q    <= '0;
    end else begin
      sig_q    <= sig_d;
      offset_q <= offset_d;
      width_q  <= width_d;
      height_q <= height_d;
      bpp_q    <= bpp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.check) begin
      padded_q     <= padded_full[ROW_W-1:0];
      data_bytes_q <= prod[ROW_W-1:0];
      height_neg_q <= height_q[31];
      height_m1_q  <= height_q[31] ? ~height_q : height_q - 32'd1;
    end
  end

  assign info_o.status      = status;
  assign info_o.data_offset = offset_q;
  assign info_o.bpb         = bpb;
  assign info_o.width       = width_q[ROW_W-1:0];
  assign info_o.padded      = padded_q;
  assign info_o.data_bytes  = data_bytes_q;
  assign info_o.height_neg  = height_neg_q;
  assign info_o.height_m1   = height_m1_q;

endmodule

// File: sv/b2r_walk.sv
// Phase control, row walk and RGB565 pixel forming of the BMP stream decoder.
`timescale 1ns / 1ps

module b2r_walk (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [7:0]         data_byte_i,
  input  logic               first_i,
  input  logic [15:0]        origin_x_i,
  input  logic [15:0]        origin_y_i,
  input  b2r_pkg::hdr_info_t hdr_i,
  output b2r_pkg::hdr_ctrl_t hdr_ctrl_o,
  output logic               emit_o,
  output b2r_pkg::result_t   res_o
);
  import b2r_pkg::*;

  phase_e           phase_q, phase_d;
  logic [31:0]      pos_q, pos_d;
  logic [ROW_W-1:0] rbi_q, rbi_d;
  logic [1:0]       k_q, k_d;
  logic [ROW_W-1:0] col_q, col_d;
  logic [31:0]      row_q, row_d;
  logic [23:0]      pa_q, pa_d;

  phase_e           cur_phase;
  logic [31:0]      pos;
  logic             pix_go;
  logic [23:0]      asm;
  logic             pix_done;
  logic             in_data;
  logic [ROW_W:0]   col_inc;
  logic [ROW_W:0]   rbi_inc;
  logic             row_end;
  logic             last;
  logic [15:0]      img_row;
  logic [15:0]      pixel16;

  always_comb begin
    cur_phase = first_i ? PH_HEADER : phase_q;
    pos       = first_i ? '0 : pos_q;
    pix_go    = (cur_phase == PH_PIXELS) ||
                ((cur_phase == PH_SKIP) && (pos >= hdr_i.data_offset));

    asm = pa_q;
    unique case (k_q)
      2'd0: asm = {16'd0, data_byte_i};
      2'd1: asm[15:8] = data_byte_i;
      2'd2: asm[23:16] = data_byte_i;
      2'd3: ;
    endcase

    pix_done = {1'b0, k_q} == (hdr_i.bpb - 3'd1);
    in_data  = rbi_q < hdr_i.data_bytes;
    col_inc  = {1'b0, col_q} + {{ROW_W{1'b0}}, 1'b1};
    rbi_inc  = {1'b0, rbi_q} + {{ROW_W{1'b0}}, 1'b1};
    row_end  = rbi_inc >= {1'b0, hdr_i.padded};
    last     = (col_inc == {1'b0, hdr_i.width}) && (row_q == hdr_i.height_m1);
    img_row  = hdr_i.height_neg ? row_q[15:0] : hdr_i.height_m1[15:0] - row_q[15:0];
    pixel16  = (hdr_i.bpb == BPB_16) ? asm[15:0] : {asm[23:19], asm[15:10], asm[7:3]};

    hdr_ctrl_o.wr    = en_i && (cur_phase == PH_HEADER);
    hdr_ctrl_o.check = en_i && (cur_phase == PH_HEADER) && (pos == HDR_LAST);
    hdr_ctrl_o.clear = en_i && first_i;
    hdr_ctrl_o.pos   = pos[5:0];

    phase_d = phase_q;
    pos_d   = pos_q;
    rbi_d   = rbi_q;
    k_d     = k_q;
    col_d   = col_q;
    row_d   = row_q;
    pa_d    = pa_q;
    emit_o  = 1'b0;
    res_o   = '0;

    if (en_i) begin
      pos_d = (pos == '1) ? pos : pos + 32'd1;
      if (first_i) begin
        phase_d = PH_HEADER;
        rbi_d   = '0;
        k_d     = '0;
        col_d   = '0;
        row_d   = '0;
        pa_d    = '0;
      end
      unique case (cur_phase)
        PH_HEADER: begin
          if (pos == HDR_LAST) begin
            if (hdr_i.status != ST_PIXEL) begin
              phase_d      = PH_DONE;
              emit_o       = 1'b1;
              res_o.status = hdr_i.status;
              res_o.last   = 1'b1;
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (pix_go) begin
            phase_d = PH_PIXELS;
          end
        end
        PH_PIXELS, PH_DONE: ;
        default: ;
      endcase

      if (pix_go) begin
        if (in_data) begin
          pa_d = asm;
          if (pix_done) begin
            emit_o         = 1'b1;
            res_o.pixel    = pixel16;
            res_o.screen_x = origin_x_i + {{(16-ROW_W){1'b0}}, col_q};
            res_o.screen_y = origin_y_i + img_row;
            res_o.status   = ST_PIXEL;
            res_o.last     = last;
            if (last) begin
              phase_d = PH_DONE;
            end
            col_d = col_inc[ROW_W-1:0];
            k_d   = '0;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
        if (row_end) begin
          rbi_d = '0;
          col_d = '0;
          k_d   = '0;
          row_d = row_q + 32'd1;
        end else begin
          rbi_d = rbi_inc[ROW_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      rbi_q   <= '0;
      k_q     <= '0;
      col_q   <= '0;
      row_q   <= '0;
      pa_q    <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      rbi_q   <= rbi_d;
      k_q     <= k_d;
      col_q   <= col_d;
      row_q   <= row_d;
      pa_q    <= pa_d;
    end
  end

endmodule

// File: sv/bmp_stream_to_rgb565.sv
// Top level of the BMP file byte stream to RGB565 pixel decoder.
// Takes one BMP file byte per transfer and gives out RGB565 pixels with
// their screen coordinates (origin plus column, origin plus top-down row).
// Bytes pass an input register, the header capture or row-walk logic,
// and an output register that holds each result until it is taken;
// a new byte is taken every cycle as long as the output side takes results.
// The 54-byte header is checked
// at its last byte; a bad signature, depth other than 16/24/32, a padded
// row over 964 bytes, a data offset inside the header or an empty image
// ends the image with one status result marked last. Bytes after the final
// pixel or a status result are dropped until a byte flagged first.
// The user must write origin_x (index 0) and origin_y (index 1) only while
// idle, which the block does not enforce; other indexes are ignored.
`timescale 1ns / 1ps

module bmp_stream_to_rgb565 (
  input  logic      clk_i,
  input  logic      rst_ni,
  b2r_in_if.sink    in_ch,
  b2r_out_if.source out_ch,
  b2r_cfg_if.sink   cfg_ch
);
  import b2r_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_first_q;
  logic        out_valid_q;
  result_t     out_res_q;
  logic [15:0] origin_x_q;
  logic [15:0] origin_y_q;

  logic        out_ok;
  logic        fire;
  logic        in_ready;
  logic        emit;
  result_t     res;
  hdr_ctrl_t   hdr_ctrl;
  hdr_info_t   hdr_info;

  assign out_ok   = !out_valid_q || out_ch.ready;
  assign fire     = in_valid_q && out_ok;
  assign in_ready = !in_valid_q || out_ok;

  assign in_ch.ready     = in_ready;
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_q;
  assign out_ch.pixel    = out_res_q.pixel;
  assign out_ch.screen_x = out_res_q.screen_x;
  assign out_ch.screen_y = out_res_q.screen_y;
  assign out_ch.status   = out_res_q.status;
  assign out_ch.last     = out_res_q.last;

  b2r_hdr u_hdr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (hdr_ctrl),
    .data_byte_i (in_byte_q),
    .info_o      (hdr_info)
  );

  b2r_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (fire),
    .data_byte_i (in_byte_q),
    .first_i     (in_first_q),
    .origin_x_i  (origin_x_q),
    .origin_y_i  (origin_y_q),
    .hdr_i       (hdr_info),
    .hdr_ctrl_o  (hdr_ctrl),
    .emit_o      (emit),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_ch.valid;
      end
      if (out_ok) begin
        out_valid_q <= fire && emit;
      end
      if (cfg_ch.valid) begin
        unique case (cfg_reg_e'(cfg_ch.reg_index))
          CFG_ORIGIN_X: origin_x_q <= cfg_ch.wdata;
          CFG_ORIGIN_Y: origin_y_q <= cfg_ch.wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_ch.valid) begin
      in_byte_q  <= in_ch.data_byte;
      in_first_q <= in_ch.first;
    end
    if (fire && emit) begin
      out_res_q <= res;
    end
  end

endmodule

// File: tb/sv/tb_bmp_stream_to_rgb565.sv
// Testbench for the BMP byte stream to RGB565 decoder: predicted pixels and status results.
`timescale 1ns / 1ps

import b2r_pkg::*;

class rgb565_scoreboard;
  result_t     pending_pixels[$];
  int unsigned fails;

  logic [15:0] org_x, org_y;
  phase_e      phase;
  logic [31:0] byte_pos, data_ofs, img_w, img_h;
  logic [15:0] sig, bpp;
  logic [10:0] row_pad, row_byte;
  logic [9:0]  col;
  logic [31:0] row;
  logic [23:0] assembly;

  function new();
    org_x = '0;
    org_y = '0;
    fails = 0;
    clear_image();
  endfunction

  function void clear_image();
    phase    = PH_HEADER;
    byte_pos = '0;
    data_ofs = '0;
    img_w    = '0;
    img_h    = '0;
    sig      = '0;
    bpp      = '0;
    row_pad  = '0;
    row_byte = '0;
    col      = '0;
    row      = '0;
    assembly = '0;
  endfunction

  function void set_origin(cfg_reg_e idx, logic [15:0] v);
    case (idx)
      CFG_ORIGIN_X: org_x = v;
      CFG_ORIGIN_Y: org_y = v;
      default: ;
    endcase
  endfunction

  function logic [31:0] gather(logic [31:0] f, logic [31:0] pos, logic [5:0] ofs,
                               int unsigned len, logic [7:0] b);
    if (pos >= 32'(ofs) && pos < 32'(ofs) + len) begin
      return f | (32'(b) << (8 * (pos - 32'(ofs))));
    end
    return f;
  endfunction

  function status_e header_status();
    logic [63:0] padded;
    if (sig != BMP_SIG) return ST_BAD_SIG;
    if (bpp != BPP_16 && bpp != BPP_24 && bpp != BPP_32) return ST_BAD_DEPTH;
    if (img_w[31]) return ST_TOO_WIDE;
    padded = (64'(img_w) * 64'(bpp >> 3) + 64'd3) & ~64'd3;
    if (padded > 64'(ROW_BYTES_MAX)) return ST_TOO_WIDE;
    row_pad = 11'(padded);
    if (data_ofs < HDR_LEN) return ST_BAD_OFFSET;
    if (img_w == 0 || img_h == 0) return ST_EMPTY;
    return ST_PIXEL;
  endfunction

  function void note_byte(logic [7:0] b, logic f);
    logic [31:0] pos, bpb, nxt, k, hm, img_row;
    logic [23:0] a;
    status_e     st;
    result_t     r;
    if (f) clear_image();
    pos = byte_pos;
    if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
    if (phase == PH_HEADER) begin
      sig      = 16'(gather(32'(sig), pos, OFS_SIG, 2, b));
      data_ofs = gather(data_ofs, pos, OFS_OFFSET, 4, b);
      img_w    = gather(img_w, pos, OFS_WIDTH, 4, b);
      img_h    = gather(img_h, pos, OFS_HEIGHT, 4, b);
      bpp      = 16'(gather(32'(bpp), pos, OFS_BPP, 2, b));
      if (pos == HDR_LAST) begin
        st = header_status();
        if (st != ST_PIXEL) begin
          phase      = PH_DONE;
          r.pixel    = '0;
          r.screen_x = '0;
          r.screen_y = '0;
          r.status   = st;
          r.last     = 1'b1;
          pending_pixels.push_back(r);
        end else begin
          phase = PH_SKIP;
        end
      end
      return;
    end
    if (phase == PH_SKIP) begin
      if (pos < data_ofs) return;
      phase = PH_PIXELS;
    end
    if (phase != PH_PIXELS) return;
    bpb = 32'(bpp >> 3);
    if (32'(row_byte) < img_w * bpb) begin
      k = 32'(row_byte) % bpb;
      if (k == 0) assembly = 24'(b);
      else if (k < 3) assembly = assembly | (24'(b) << (8 * k));
      if (k == bpb - 1) begin
        a          = assembly;
        hm         = img_h[31] ? 32'd0 - img_h : img_h;
        img_row    = img_h[31] ? row : hm - 32'd1 - row;
        r.pixel    = (bpb == 32'(BPB_16)) ? a[15:0] : {a[23:19], a[15:10], a[7:3]};
        r.screen_x = org_x + 16'(col);
        r.screen_y = org_y + img_row[15:0];
        r.status   = ST_PIXEL;
        r.last     = 1'b0;
        if (32'(col) + 1 == img_w && row + 1 == hm) begin
          r.last = 1'b1;
          phase  = PH_DONE;
        end
        pending_pixels.push_back(r);
        col = col + 10'd1;
      end
    end
    nxt = 32'(row_byte) + 1;
    if (nxt >= 32'(row_pad)) begin
      row_byte = '0;
      col      = '0;
      row      = row + 1;
    end else begin
      row_byte = 11'(nxt);
    end
  endfunction

  function void compare(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
    end
  endfunction

  function void check_pixel(result_t got);
    result_t want;
    if (pending_pixels.size() == 0) begin
      fails++;
      $display("%0t: unexpected result, expected none, actual pixel %h x %h y %h status %0d last %b",
               $time, got.pixel, got.screen_x, got.screen_y, got.status, got.last);
      return;
    end
    want = pending_pixels.pop_front();
    compare("pixel", want.pixel, got.pixel);
    compare("screen_x", want.screen_x, got.screen_x);
    compare("screen_y", want.screen_y, got.screen_y);
    compare("status", 16'(want.status), 16'(got.status));
    compare("last", 16'(want.last), 16'(got.last));
  endfunction
endclass

module tb_bmp_stream_to_rgb565;

  localparam int unsigned CYCLE_LIMIT = 20_000;
  localparam logic [1:0]  CFG_UNUSED  = 2'd2;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  int unsigned cycle_count = 0;
  int unsigned byte_count;
  rgb565_scoreboard board = new();

  b2r_in_if  in_ch ();
  b2r_out_if out_ch ();
  b2r_cfg_if cfg_ch ();

  bmp_stream_to_rgb565 u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    result_t seen;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.pixel    = out_ch.pixel;
      seen.screen_x = out_ch.screen_x;
      seen.screen_y = out_ch.screen_y;
      seen.status   = status_e'(out_ch.status);
      seen.last     = out_ch.last;
      board.check_pixel(seen);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic f);
    while (!calm && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.first     <= f;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    board.note_byte(b, f);
  endtask

  task automatic noise(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_origin(cfg_reg_e idx, logic [15:0] v);
    settle();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= v;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    board.set_origin(idx, v);
  endtask

  function automatic int unsigned image_len(logic [31:0] ofs, logic [31:0] w,
                                            logic [31:0] hmag, logic [15:0] bpp);
    return ofs + ((w * 32'(bpp >> 3) + 32'd3) & ~32'd3) * hmag;
  endfunction

  task automatic send_image(logic [15:0] sig, logic [31:0] ofs, logic [31:0] w,
                            logic [31:0] h, logic [15:0] bpp, int unsigned total,
                            int fill, bit mark);
    logic [7:0] hdr [54];
    logic [7:0] b;
    for (int i = 0; i < 54; i++) hdr[i] = 8'($urandom);
    for (int j = 0; j < 2; j++) begin
      hdr[OFS_SIG + j] = sig[8*j +: 8];
      hdr[OFS_BPP + j] = bpp[8*j +: 8];
    end
    for (int j = 0; j < 4; j++) begin
      hdr[OFS_OFFSET + j] = ofs[8*j +: 8];
      hdr[OFS_WIDTH + j]  = w[8*j +: 8];
      hdr[OFS_HEIGHT + j] = h[8*j +: 8];
    end
    for (int unsigned i = 0; i < total; i++) begin
      if (i < 54) b = hdr[i];
      else if (fill < 0) b = 8'($urandom);
      else b = 8'(fill);
      send_byte(b, mark && i == 0);
    end
    byte_count += total;
  endtask

  task automatic send_bitmap(logic [31:0] w, logic [31:0] hmag, bit top_down,
                             logic [15:0] bpp, logic [31:0] ofs, int fill);
    send_image(BMP_SIG, ofs, w, top_down ? 32'd0 - hmag : hmag, bpp,
               image_len(ofs, w, hmag, bpp), fill, 1'b1);
  endtask

  function automatic logic [15:0] pick_depth();
    case ($urandom_range(2))
      0:       return BPP_16;
      1:       return BPP_24;
      default: return BPP_32;
    endcase
  endfunction

  task automatic random_image();
    int unsigned pick, total;
    logic [31:0] w, hmag, h, ofs;
    logic [15:0] bpp, sig;
    pick = $urandom_range(99);
    sig  = BMP_SIG;
    bpp  = pick_depth();
    w    = $urandom_range(1, 6);
    if ($urandom_range(9) == 0) w = $urandom_range(7, 24);
    hmag = $urandom_range(1, 3);
    h    = $urandom_range(1) ? 32'd0 - hmag : hmag;
    ofs  = 54 + $urandom_range(0, 6);
    if (pick < 70) begin
      total = image_len(ofs, w, hmag, bpp);
      if ($urandom_range(9) == 0) total = $urandom_range(1, total);
      send_image(sig, ofs, w, h, bpp, total, -1, 1'b1);
    end else begin
      if (pick < 76) begin
        sig = 16'($urandom);
        if (sig == BMP_SIG) sig = ~sig;
      end else if (pick < 82) begin
        bpp = 16'($urandom);
        if (bpp == BPP_16 || bpp == BPP_24 || bpp == BPP_32) bpp = 16'd8;
      end else if (pick < 88) begin
        case ($urandom_range(2))
          0:       w = 32'h8000_0000 | $urandom;
          1:       w = 32'h0100_0000 | $urandom;
          default: w = 490 + $urandom_range(0, 1000);
        endcase
      end else if (pick < 94) begin
        ofs = $urandom_range(0, 53);
      end else if ($urandom_range(1)) begin
        w = '0;
      end else begin
        h = '0;
      end
      send_image(sig, ofs, w, h, bpp, 54, -1, 1'b1);
    end
    noise($urandom_range(0, 3));
  endtask

  initial begin
    rst_n            = 1'b0;
    calm             = 1'b0;
    byte_count       = 0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.first      = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = CFG_ORIGIN_X;
    cfg_ch.wdata     = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unmarked stream right after reset, then trailing bytes that are dropped
    send_image(BMP_SIG, 54, 1, 1, BPP_16, 58, -1, 1'b0);
    noise(3);
    send_bitmap(3, 2, 1'b1, BPP_24, 58, -1);
    send_image(16'h4D43, 54, 1, 1, BPP_16, 54, -1, 1'b1);
    noise(2);
    send_image(BMP_SIG, 54, 1, 1, 16'd8, 54, -1, 1'b1);
    send_image(BMP_SIG, 54, 322, 1, BPP_24, 54, -1, 1'b1);
    send_image(BMP_SIG, 53, 1, 1, BPP_16, 54, -1, 1'b1);
    // most negative height, cut short by the next file
    calm = 1'b1;
    send_image(BMP_SIG, 54, 2, 32'h8000_0000, BPP_16, 60, -1, 1'b1);
    calm = 1'b0;
    // restart inside the header
    send_image(BMP_SIG, 54, 1, 1, BPP_16, 30, -1, 1'b1);

    write_origin(CFG_ORIGIN_X, 16'hFFFF);
    write_origin(CFG_ORIGIN_Y, 16'hFFFF);
    write_origin(cfg_reg_e'(CFG_UNUSED), 16'($urandom));
    send_bitmap(1, 2, 1'b0, BPP_32, 55, 8'hFF);

    write_origin(CFG_ORIGIN_X, 16'($urandom));
    write_origin(CFG_ORIGIN_Y, 16'($urandom));
    calm       = 1'b1;
    byte_count = 0;
    while (byte_count < 40) random_image();
    calm = 1'b0;

    settle();
    if (board.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
